// ----- rtl/core/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache: request and result
// words, operation codes and the controller command bundle.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int CAP_BITS    = 5;
  localparam int CAP_RESET   = 16;
  localparam int DEF_ENTRIES = 16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                           op;
    logic signed [KEY_BITS-1:0]    key;
    logic signed [VALUE_BITS-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                          hit;
    logic signed [VALUE_BITS-1:0]  read_value;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a request word
    logic exec;       // compare keys and update entries
    logic cfg_write;  // capacity write handshake
  } ctl_cmd_t;

endpackage

// ----- rtl/core/lkvc_ram.sv -----
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lkvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: accept, lookup/update, present result. A new request is
// taken in the cycle the previous result is shown.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  output logic               res_valid_o,
  output lkvc_pkg::ctl_cmd_t cmd_o
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESPOND
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   res_valid_q;
  logic   load;

  assign load = start && !busy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_RESPOND: begin
        state_d = load ? ST_LOOKUP : ST_IDLE;
      end
      ST_LOOKUP: begin
        state_d = ST_RESPOND;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= (state_d == ST_LOOKUP);
      res_valid_q <= (state_d == ST_RESPOND);
    end
  end

  assign busy          = busy_q;
  assign cfg_ready_o   = !busy_q;
  assign res_valid_o   = res_valid_q;
  assign cmd_o.load      = load;
  assign cmd_o.exec      = busy_q;
  assign cmd_o.cfg_write = cfg_valid_i && !busy_q;

  // Every lookup produces exactly one result in the following cycle
  a_lookup_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_valid_o)
    else $error("lookup not followed by result strobe");

  a_result_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(busy))
    else $error("result strobe without preceding lookup");

endmodule

// ----- rtl/core/lkvc_datapath.sv -----
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry storage and update logic: per-entry key compare, recency ranks,
// occupancy and capacity, value RAM and result formatting.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
  parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lkvc_pkg::ctl_cmd_t               cmd_i,
  input  lkvc_pkg::req_t                   req_i,
  input  logic [lkvc_pkg::CAP_BITS-1:0]    cfg_data_i,
  output lkvc_pkg::res_t                   res_o
);
  import lkvc_pkg::*;

  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW     = $clog2(ENTRIES + 1);
  localparam int CW     = (OW > CAP_BITS) ? OW : CAP_BITS;
  localparam int CapRst = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

  req_t                  item_q;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q  [ENTRIES];
  logic [IW-1:0]         rank_q [ENTRIES];
  logic [IW-1:0]         rank_d [ENTRIES];
  logic [OW-1:0]         occ_q, occ_d;
  logic [OW-1:0]         cap_q;
  logic                  resp_hit_q;
  logic                  resp_get_q;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    oldest;
  logic [ENTRIES-1:0]    sel;
  logic [ENTRIES-1:0]    pick;
  logic [IW-1:0]         slot;
  logic [IW-1:0]         slot_rank;
  logic [IW-1:0]         last_rank;
  logic                  hit;
  logic                  has_room;
  logic                  is_put;
  logic [CW-1:0]         cap_in;
  logic [CW-1:0]         cap_max;
  logic [CW-1:0]         cap_live;
  logic [VALUE_BITS-1:0] rdata;

  assign last_rank = IW'(occ_q - 1'b1);
  assign is_put    = (item_q.op == OP_PUT);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == item_q.key);
      oldest[i] = valid_q[i] && (rank_q[i] == last_rank);
    end
  end

  assign hit      = |match;
  assign has_room = (occ_q < cap_q);
  // Target: the hit entry, else the lowest free slot, else the LRU entry
  assign sel      = hit ? match : (has_room ? ~valid_q : oldest);
  assign pick     = sel & (~sel + ENTRIES'(1));

  always_comb begin
    slot      = '0;
    slot_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (pick[i]) begin
        slot      = slot | IW'(i);
        slot_rank = slot_rank | rank_q[i];
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.exec) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (pick[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < slot_rank)) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
      end else if (is_put) begin
        // Insert as most recent; everyone else ages by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (pick[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        valid_d = valid_q | pick;
        if (has_room) begin
          occ_d = occ_q + 1'b1;
        end
      end
    end
  end

  // Clamp capacity to 1..ENTRIES at write time
  assign cap_in   = CW'(cfg_data_i);
  assign cap_max  = CW'(ENTRIES);
  assign cap_live = (cap_in == '0) ? CW'(1) : ((cap_in > cap_max) ? cap_max : cap_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      cap_q   <= OW'(CapRst);
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
      if (cmd_i.cfg_write && (occ_q == '0)) begin
        cap_q <= OW'(cap_live);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= req_i;
    end
    if (cmd_i.exec) begin
      resp_hit_q <= hit;
      resp_get_q <= !is_put;
      for (int i = 0; i < ENTRIES; i++) begin
        if (is_put && !hit && pick[i]) begin
          key_q[i] <= item_q.key;
        end
      end
    end
  end

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && is_put),
    .addr_i  (slot),
    .wdata_i (item_q.value),
    .rdata_o (rdata)
  );

  assign res_o.hit        = resp_hit_q;
  assign res_o.read_value = resp_get_q ? (resp_hit_q ? rdata : '1) : '0;

  a_occ_counts_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q)
    else $error("occupancy out of step with valid entries");

  a_occ_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap_q)
    else $error("occupancy above capacity");

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low and takes two cycles:
// one in which all stored keys are compared in parallel and the entry, rank
// and value RAM updates happen, and one in which the result is shown for a
// single cycle with res_valid_o high (the value RAM read is registered). The
// next request may be taken in that result cycle, so back-to-back requests
// run at one every two cycles. Results cannot be held off: capture them in the
// cycle res_valid_o is high. A get miss returns all ones, a put returns zero.
// The capacity write takes effect only while the store is empty; zero reads
// as one and values above ENTRIES as ENTRIES. No clearing pass is needed after
// reset.
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lkvc_pkg::req_t                req_i,
  output logic                          res_valid_o,
  output lkvc_pkg::res_t                res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_data_i
);
  import lkvc_pkg::*;

  ctl_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_o)
  );

endmodule
